// ----- sv/pkc_pkg.sv -----
// package for the page chunk free list allocator
// holds widths, codes, clamp helper and the control structs; no dependencies

package pkc_pkg;

   // fixed page geometry
   localparam int PAGE_BYTES = 4096;
   localparam int MAX_CHUNKS = 256;
   localparam int IDX_W      = $clog2(MAX_CHUNKS);
   localparam int CNT_W      = IDX_W + 1;

   // field widths
   localparam int OFF_W  = 12;
   localparam int SIZE_W = 12;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 12;

   // chunk size limits
   localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(16);
   localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(2048);
   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

   // divider: dividend covers the page size itself
   localparam int DIV_W   = $clog2(PAGE_BYTES) + 1;
   localparam int DIVC_W  = $clog2(DIV_W + 1);
   localparam logic [DIV_W-1:0] PAGE_DIVIDEND = DIV_W'(PAGE_BYTES);

   // chunk count after reset, for the reset chunk size
   localparam int CHUNKS_AT_RESET =
      (PAGE_BYTES / 16 > MAX_CHUNKS) ? MAX_CHUNKS : PAGE_BYTES / 16;

   // request codes
   localparam logic [1:0] REQ_ALLOC   = 2'd0;
   localparam logic [1:0] REQ_FREE    = 2'd1;
   localparam logic [1:0] REQ_REBUILD = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NO_FREE = 2'd1;
   localparam logic [1:0] ST_BAD_OFF = 2'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK_SIZE    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_RESERVE_FIRST = CSR_IDX_W'(1);

   // divider request and result
   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  dividend;
      logic [SIZE_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIV_W-1:0]  quot;
      logic [SIZE_W-1:0] rem;
   } div_rsp_type;

   // configuration seen by the sequencer
   typedef struct packed {
      logic              size_upd;
      logic [SIZE_W-1:0] size;
      logic              reserve;
   } cfg_type;

   // sequencer status to the top level
   typedef struct packed {
      logic idle;
   } ctrl_stat_type;

   // effective chunk size, clamped to the legal range
   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] raw);
      logic [SIZE_W-1:0] s;
      s = raw;
      if (s < SIZE_MIN) s = SIZE_MIN;
      if (s > SIZE_MAX) s = SIZE_MAX;
      return s;
   endfunction

endpackage

// ----- sv/pkc_req_if.sv -----
// request channel interface: valid, ready and request payload
// depends on pkc_pkg for field widths

interface pkc_req_if import pkc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [1:0]       req_type;
   logic [OFF_W-1:0] chunk_offset;

   modport source (output valid, req_type, chunk_offset, input ready);
   modport sink   (input valid, req_type, chunk_offset, output ready);
endinterface

// ----- sv/pkc_rsp_if.sv -----
// result channel interface: valid, ready and result payload
// depends on pkc_pkg for field widths

interface pkc_rsp_if import pkc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [1:0]       status;
   logic [OFF_W-1:0] alloc_offset;
   logic [CNT_W-1:0] free_total;
   logic             page_full;
   logic             first_returned;
   logic             page_empty;

   modport source (output valid, status, alloc_offset, free_total, page_full,
                   first_returned, page_empty, input ready);
   modport sink   (input valid, status, alloc_offset, free_total, page_full,
                   first_returned, page_empty, output ready);
endinterface

// ----- sv/pkc_csr_if.sv -----
// configuration write channel interface: valid, ready, index and data
// depends on pkc_pkg for field widths

interface pkc_csr_if import pkc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/pkc_div.sv -----
// shared restoring divider, one quotient bit per cycle
// depends on pkc_pkg for widths and the divider structs

module pkc_div import pkc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIVC_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]  quot_ff, quot_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [SIZE_W-1:0] dsor_ff, dsor_in;

   logic [DIV_W-1:0]  shifted;
   logic [DIV_W:0]    diff;
   logic              ge;

   // one trial subtraction per step
   always_comb begin
      shifted = {rem_ff[DIV_W-2:0], quot_ff[DIV_W-1]};
      diff    = {1'b0, shifted} - {{(DIV_W + 1 - SIZE_W){1'b0}}, dsor_ff};
      ge      = ~diff[DIV_W];
   end

   // step sequencing
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dsor_in = dsor_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quot_in = div_req.dividend;
         rem_in  = '0;
         dsor_in = div_req.divisor;
      end else if (busy_ff) begin
         quot_in = {quot_ff[DIV_W-2:0], ge};
         rem_in  = ge ? diff[DIV_W-1:0] : shifted;
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == DIVC_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dsor_ff <= dsor_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;
   assign div_rsp.rem  = rem_ff[SIZE_W-1:0];

endmodule

// ----- sv/pkc_ctrl.sv -----
// request sequencer: free list state, link table memory and result register
// depends on pkc_pkg; drives the shared divider pkc_div through div_req

module pkc_ctrl import pkc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_type,
   input  logic [OFF_W-1:0] req_offset,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [OFF_W-1:0] rsp_alloc_offset,
   output logic [CNT_W-1:0] rsp_free_total,
   output logic             rsp_page_full,
   output logic             rsp_first_returned,
   output logic             rsp_page_empty,
   output div_req_type      div_req,
   input  div_rsp_type      div_rsp,
   output ctrl_stat_type    stat
);

   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_CALC    = 6'b000010,
      S_DIVF    = 6'b000100,
      S_ALLOC   = 6'b001000,
      S_REBUILD = 6'b010000,
      S_FINISH  = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  chunks_ff, chunks_in;
   logic [CNT_W-1:0]  walk_ff, walk_in;
   logic [1:0]        status_ff, status_in;
   logic [OFF_W-1:0]  aoff_ff, aoff_in;
   logic              ret_ff, ret_in;

   // result register
   logic              out_valid_ff, out_valid_in;
   logic [1:0]        out_status_ff, out_status_in;
   logic [OFF_W-1:0]  out_aoff_ff, out_aoff_in;
   logic [CNT_W-1:0]  out_total_ff, out_total_in;
   logic              out_full_ff, out_full_in;
   logic              out_ret_ff, out_ret_in;
   logic              out_empty_ff, out_empty_in;

   // link table
   logic [IDX_W-1:0]  link_mem [MAX_CHUNKS];
   logic [IDX_W-1:0]  link_rd_ff;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;

   logic              accept;
   logic [CNT_W-1:0]  usable;
   logic [CNT_W-1:0]  first_ix;
   logic [OFF_W+SIZE_W-1:0] product;
   logic              bad_free;
   logic              load_out;

   assign req_ready = (state_ff == S_IDLE) && !cfg.size_upd;
   assign accept    = req_valid && req_ready;
   assign usable    = chunks_ff - {{(CNT_W-1){1'b0}}, cfg.reserve};
   assign first_ix  = {{(CNT_W-1){1'b0}}, cfg.reserve};
   assign product   = {{(OFF_W+SIZE_W-IDX_W){1'b0}}, head_ff} * cfg.size;
   assign load_out  = (state_ff == S_FINISH) && (!out_valid_ff || rsp_ready);
   assign stat.idle = (state_ff == S_IDLE);

   // free checks on the divider result
   always_comb begin
      bad_free = (div_rsp.rem != '0) ||
                 (div_rsp.quot >= {{(DIV_W-CNT_W){1'b0}}, chunks_ff}) ||
                 (cfg.reserve && (div_rsp.quot == '0)) ||
                 (count_ff >= usable);
   end

   // divider launch: chunk count after a size write, or a free offset
   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = PAGE_DIVIDEND;
      div_req.divisor  = cfg.size;
      if (state_ff == S_IDLE) begin
         if (cfg.size_upd) begin
            div_req.start = 1'b1;
         end else if (accept && (req_type == REQ_FREE)) begin
            div_req.start    = 1'b1;
            div_req.dividend = {{(DIV_W-OFF_W){1'b0}}, req_offset};
         end
      end
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      chunks_in = chunks_ff;
      walk_in   = walk_ff;
      status_in = status_ff;
      aoff_in   = aoff_ff;
      ret_in    = ret_ff;
      wr_en     = 1'b0;
      wr_addr   = head_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cfg.size_upd) begin
               state_in = S_CALC;
            end else if (accept) begin
               status_in = ST_OK;
               aoff_in   = '0;
               ret_in    = 1'b0;
               case (req_type)
                  REQ_ALLOC: begin
                     if (count_ff == '0) begin
                        status_in = ST_NO_FREE;
                        state_in  = S_FINISH;
                     end else begin
                        state_in = S_ALLOC;
                     end
                  end
                  REQ_FREE: state_in = S_DIVF;
                  REQ_REBUILD: begin
                     head_in  = '0;
                     count_in = '0;
                     walk_in  = first_ix;
                     state_in = S_REBUILD;
                  end
                  default: state_in = S_FINISH;
               endcase
            end
         end
         S_CALC: begin
            if (div_rsp.done) begin
               if (div_rsp.quot > DIV_W'(MAX_CHUNKS))
                  chunks_in = CNT_W'(MAX_CHUNKS);
               else
                  chunks_in = div_rsp.quot[CNT_W-1:0];
               state_in = S_IDLE;
            end
         end
         S_DIVF: begin
            if (div_rsp.done) begin
               if (bad_free) begin
                  status_in = ST_BAD_OFF;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = div_rsp.quot[IDX_W-1:0];
                  head_in  = div_rsp.quot[IDX_W-1:0];
                  count_in = count_ff + 1'b1;
                  ret_in   = (count_ff == '0);
               end
               state_in = S_FINISH;
            end
         end
         S_ALLOC: begin
            // link_rd_ff holds the entry after the head
            aoff_in  = product[OFF_W-1:0];
            count_in = count_ff - 1'b1;
            head_in  = (count_ff == CNT_W'(1)) ? '0 : link_rd_ff;
            state_in = S_FINISH;
         end
         S_REBUILD: begin
            if (walk_ff < chunks_ff) begin
               wr_en    = 1'b1;
               wr_addr  = walk_ff[IDX_W-1:0];
               head_in  = walk_ff[IDX_W-1:0];
               count_in = count_ff + 1'b1;
               walk_in  = walk_ff + 1'b1;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (load_out) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // result register load and drain
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_status_in = out_status_ff;
      out_aoff_in   = out_aoff_ff;
      out_total_in  = out_total_ff;
      out_full_in   = out_full_ff;
      out_ret_in    = out_ret_ff;
      out_empty_in  = out_empty_ff;
      if (rsp_ready) out_valid_in = 1'b0;
      if (load_out) begin
         out_valid_in  = 1'b1;
         out_status_in = status_ff;
         out_aoff_in   = aoff_ff;
         out_total_in  = count_ff;
         out_full_in   = (count_ff == '0);
         out_ret_in    = ret_ff;
         out_empty_in  = (count_ff == usable);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         chunks_ff    <= CNT_W'(CHUNKS_AT_RESET);
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         chunks_ff    <= chunks_in;
         out_valid_ff <= out_valid_in;
      end
      walk_ff       <= walk_in;
      status_ff     <= status_in;
      aoff_ff       <= aoff_in;
      ret_ff        <= ret_in;
      out_status_ff <= out_status_in;
      out_aoff_ff   <= out_aoff_in;
      out_total_ff  <= out_total_in;
      out_full_ff   <= out_full_in;
      out_ret_ff    <= out_ret_in;
      out_empty_ff  <= out_empty_in;
   end

   // link table: one write port, registered read at the head
   always_ff @(posedge clock) begin
      if (wr_en) link_mem[wr_addr] <= head_ff;
      link_rd_ff <= link_mem[head_ff];
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_status         = out_status_ff;
   assign rsp_alloc_offset   = out_aoff_ff;
   assign rsp_free_total     = out_total_ff;
   assign rsp_page_full      = out_full_ff;
   assign rsp_first_returned = out_ret_ff;
   assign rsp_page_empty     = out_empty_ff;

endmodule

// ----- sv/page_chunk_free_list_allocator.sv -----
// top level of the page chunk free list allocator
// depends on pkc_pkg, the three channel interfaces, pkc_div and pkc_ctrl
//
// usage:
//   req_bus carries one request: req_type (alloc, free, rebuild) and
//   chunk_offset (used by free). rsp_bus returns one result per request:
//   status, alloc_offset, free_total, page_full, first_returned, page_empty.
//   csr_bus writes chunk_size (index 0) and reserve_first (index 1).
// steps, from acceptance to the result in the output register:
//   alloc passes S_ALLOC and S_FINISH; unused code 3 and an alloc on an
//   empty list go straight to S_FINISH; free waits in S_DIVF for the
//   13-step shared divider that turns the offset into a chunk index;
//   rebuild makes one link table write per usable chunk. a chunk_size
//   write starts a 13-step division of the page size that refreshes the
//   chunk count; requests and further writes wait until it is refreshed.
//   a write is not taken while a request is offered.
//   one request is in work at a time; the next is taken once the result
//   sits in the output register.
// reset:
//   the free list is empty (head 0, count 0), chunk_size is 16 and
//   reserve_first is 0; the link table holds no defined data until a
//   rebuild or free writes it.
// stall:
//   a result waits in the output register while rsp_bus.ready is low; a
//   finished request holds in its last step until that register drains.

module page_chunk_free_list_allocator import pkc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   pkc_req_if.sink   req_bus,
   pkc_rsp_if.source rsp_bus,
   pkc_csr_if.sink   csr_bus
);

   logic [SIZE_W-1:0] chunk_size_ff, chunk_size_in;
   logic              reserve_ff, reserve_in;
   logic              csr_write;
   logic              size_upd_ff;

   cfg_type       cfg;
   ctrl_stat_type stat;
   div_req_type   div_req;
   div_rsp_type   div_rsp;

   // configuration registers, written only with no request in work or offered
   assign csr_bus.ready = stat.idle && !size_upd_ff && !req_bus.valid;
   assign csr_write     = csr_bus.valid && csr_bus.ready;

   always_comb begin
      chunk_size_in = chunk_size_ff;
      reserve_in    = reserve_ff;
      if (csr_write) begin
         unique case (csr_bus.index)
            CSR_CHUNK_SIZE:    chunk_size_in = csr_bus.data[SIZE_W-1:0];
            CSR_RESERVE_FIRST: reserve_in    = csr_bus.data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_size_ff <= SIZE_RESET;
         reserve_ff    <= 1'b0;
      end else begin
         chunk_size_ff <= chunk_size_in;
         reserve_ff    <= reserve_in;
      end
   end

   // size change pulse, raised in the cycle after the write so the new size is in place
   always_ff @(posedge clock) begin
      if (reset) size_upd_ff <= 1'b0;
      else       size_upd_ff <= csr_write && (csr_bus.index == CSR_CHUNK_SIZE);
   end

   assign cfg.size_upd = size_upd_ff;
   assign cfg.size     = clamp_size(chunk_size_ff);
   assign cfg.reserve  = reserve_ff;

   // shared divider
   pkc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // request sequencer
   pkc_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .req_valid          (req_bus.valid),
      .req_ready          (req_bus.ready),
      .req_type           (req_bus.req_type),
      .req_offset         (req_bus.chunk_offset),
      .rsp_valid          (rsp_bus.valid),
      .rsp_ready          (rsp_bus.ready),
      .rsp_status         (rsp_bus.status),
      .rsp_alloc_offset   (rsp_bus.alloc_offset),
      .rsp_free_total     (rsp_bus.free_total),
      .rsp_page_full      (rsp_bus.page_full),
      .rsp_first_returned (rsp_bus.first_returned),
      .rsp_page_empty     (rsp_bus.page_empty),
      .div_req            (div_req),
      .div_rsp            (div_rsp),
      .stat               (stat)
   );

endmodule
